// File: design/fbrq_pkg.sv
// fbrq_pkg: shared constants, codes and types of the framed byte ring queue
// no dependencies; imported by every module of the block but fbrq_ram
package fbrq_pkg;

  localparam int RING_BYTES = 8192;
  localparam int ADDR_W     = $clog2(RING_BYTES);
  localparam int POS_W      = ADDR_W + 1;
  localparam int LEN_W      = 13;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int STAT_W     = 3;
  localparam int CMD_W      = 2;
  localparam int CNT_W      = 3;
  localparam int CFG_ADDR_W = 3;

  // framing sizes in bytes
  localparam int FRAME_BYTES = 12;
  localparam int HDR_BYTES   = 8;
  localparam int MARK_BYTES  = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP     = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STS_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STS_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STS_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] STS_MARKER    = 3'd3;
  localparam logic [STAT_W-1:0] STS_BAD_LEN   = 3'd4;
  localparam logic [STAT_W-1:0] STS_SMALL_BUF = 3'd5;
  localparam logic [STAT_W-1:0] STS_SEQUENCE  = 3'd6;

  // register index, taken from paddr bit 2
  localparam logic REG_BEGIN = 1'b0;
  localparam logic REG_END   = 1'b1;

  localparam logic [WORD_W-1:0] END_MARKER_RESET = 32'h2444_4E3D;

  typedef struct packed {
    logic [WORD_W-1:0] begin_marker;
    logic [WORD_W-1:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSV_HDR,
    S_PUSH,
    S_END_WR,
    S_HDR_RD,
    S_HDR_CAP,
    S_HDR_EVAL,
    S_POP_BODY,
    S_POP_CAP,
    S_END_RD,
    S_END_CAP,
    S_DONE
  } state_t;

  // little-endian byte lane of a word
  function automatic logic [BYTE_W-1:0] word_byte(input logic [WORD_W-1:0] w,
                                                   input logic [1:0] idx);
    return w[{idx, 3'b000} +: BYTE_W];
  endfunction

endpackage

// File: design/fbrq_ram.sv
// fbrq_ram: generic single-port ram with registered read
// no dependencies
module fbrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/fbrq_ctrl.sv
// fbrq_ctrl: sequencer that moves framed bytes through the shared ring port
// depends on fbrq_pkg
module fbrq_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [fbrq_pkg::CMD_W-1:0]          command,
  input  logic [fbrq_pkg::BYTE_W-1:0]         data_byte,
  input  logic [fbrq_pkg::LEN_W-1:0]          payload_length,
  input  logic [fbrq_pkg::LEN_W-1:0]          buffer_limit,
  input  fbrq_pkg::cfg_t                      cfg,
  output logic                                busy,
  output logic                                res_valid,
  output logic [fbrq_pkg::STAT_W-1:0]         res_status,
  output logic [fbrq_pkg::BYTE_W-1:0]         res_data,
  output logic                                res_last,
  output logic [fbrq_pkg::LEN_W-1:0]          res_len,
  output fbrq_pkg::mem_req_t                  mem_req,
  input  logic [fbrq_pkg::BYTE_W-1:0]         mem_rdata
);
  import fbrq_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [ADDR_W-1:0]   wcur_r, wcur_nxt, rcur_r, rcur_nxt;
  logic [LEN_W-1:0]    wrem_r, wrem_nxt, rrem_r, rrem_nxt;
  logic                wopen_r, wopen_nxt, ropen_r, ropen_nxt;
  logic [LEN_W-1:0]    msg_len_r, msg_len_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt, total_r, total_nxt;
  logic                mark_ok_r, mark_ok_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [LEN_W-1:0]    plen_r, plen_nxt, blim_r, blim_nxt;
  logic [STAT_W-1:0]   sts_r, sts_nxt;
  logic [BYTE_W-1:0]   dout_r, dout_nxt;
  logic                last_r, last_nxt;
  logic [LEN_W-1:0]    mlen_r, mlen_nxt;

  logic [ADDR_W-1:0]   used_mod;
  logic [POS_W-1:0]    free_bytes;
  logic [POS_W-1:0]    rsv_total;
  logic                rsv_full;
  logic                hdr_bad_mark, hdr_bad_len, hdr_small;
  logic [WORD_W-1:0]   shift_word;

  // space accounting, one slot always kept unused
  assign used_mod   = tail_r - head_r;
  assign free_bytes = POS_W'(RING_BYTES) - POS_W'(used_mod);
  assign rsv_total  = POS_W'(payload_length) + POS_W'(FRAME_BYTES);
  assign rsv_full   = rsv_total >= free_bytes;

  // header checks in priority order
  assign hdr_bad_mark = !mark_ok_r;
  assign hdr_bad_len  = (total_r > WORD_W'(used_mod)) || (total_r < WORD_W'(FRAME_BYTES));
  assign hdr_small    = (total_r - WORD_W'(HDR_BYTES)) > WORD_W'(blim_r);

  assign shift_word = {mem_rdata, word_r[WORD_W-1:BYTE_W]};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority if (command == CMD_RESERVE) begin
            state_nxt = rsv_full ? S_DONE : S_RSV_HDR;
          end else if (command == CMD_PUSH) begin
            state_nxt = wopen_r ? S_PUSH : S_DONE;
          end else if (command == CMD_POP) begin
            priority if (ropen_r)          state_nxt = S_POP_BODY;
            else if (head_r == tail_r)     state_nxt = S_DONE;
            else                           state_nxt = S_HDR_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RSV_HDR:  if (cnt_r == CNT_W'(HDR_BYTES - 1)) begin
                    state_nxt = (plen_r == '0) ? S_END_WR : S_DONE;
                  end
      S_PUSH:     state_nxt = (wrem_r == LEN_W'(1)) ? S_END_WR : S_DONE;
      S_END_WR:   if (cnt_r == CNT_W'(MARK_BYTES - 1)) state_nxt = S_DONE;
      S_HDR_RD:   state_nxt = S_HDR_CAP;
      S_HDR_CAP:  state_nxt = (cnt_r == CNT_W'(HDR_BYTES - 1)) ? S_HDR_EVAL : S_HDR_RD;
      S_HDR_EVAL: state_nxt = (hdr_bad_mark || hdr_bad_len || hdr_small) ? S_DONE
                                                                         : S_POP_BODY;
      S_POP_BODY: state_nxt = (rrem_r != '0) ? S_POP_CAP : S_END_RD;
      S_POP_CAP:  state_nxt = (rrem_r == LEN_W'(1)) ? S_END_RD : S_DONE;
      S_END_RD:   state_nxt = S_END_CAP;
      S_END_CAP:  state_nxt = (cnt_r == CNT_W'(MARK_BYTES - 1)) ? S_DONE : S_END_RD;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    wcur_nxt    = wcur_r;
    rcur_nxt    = rcur_r;
    wrem_nxt    = wrem_r;
    rrem_nxt    = rrem_r;
    wopen_nxt   = wopen_r;
    ropen_nxt   = ropen_r;
    msg_len_nxt = msg_len_r;
    word_nxt    = word_r;
    total_nxt   = total_r;
    mark_ok_nxt = mark_ok_r;
    byte_nxt    = byte_r;
    plen_nxt    = plen_r;
    blim_nxt    = blim_r;
    sts_nxt     = sts_r;
    dout_nxt    = dout_r;
    last_nxt    = last_r;
    mlen_nxt    = mlen_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          byte_nxt = data_byte;
          plen_nxt = payload_length;
          blim_nxt = buffer_limit;
          cnt_nxt  = '0;
          sts_nxt  = STS_OK;
          dout_nxt = '0;
          last_nxt = 1'b0;
          mlen_nxt = '0;
          priority if (command == CMD_RESERVE) begin
            // a new reserve abandons any open message
            wopen_nxt = 1'b0;
            wrem_nxt  = '0;
            if (rsv_full) begin
              sts_nxt = STS_FULL;
            end else begin
              wcur_nxt  = tail_r + ADDR_W'(HDR_BYTES);
              wrem_nxt  = payload_length;
              wopen_nxt = 1'b1;
            end
          end else if (command == CMD_PUSH) begin
            if (!wopen_r) sts_nxt = STS_SEQUENCE;
          end else if (command == CMD_POP) begin
            if (!ropen_r && (head_r == tail_r)) sts_nxt = STS_EMPTY;
          end else begin
            sts_nxt = STS_SEQUENCE;
          end
        end
      end
      S_RSV_HDR: cnt_nxt = cnt_r + CNT_W'(1);
      S_PUSH: begin
        wcur_nxt = wcur_r + ADDR_W'(1);
        wrem_nxt = wrem_r - LEN_W'(1);
        cnt_nxt  = '0;
      end
      S_END_WR: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MARK_BYTES - 1)) begin
          tail_nxt  = wcur_r + ADDR_W'(MARK_BYTES);
          wopen_nxt = 1'b0;
          wrem_nxt  = '0;
        end
      end
      S_HDR_CAP: begin
        word_nxt = shift_word;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MARK_BYTES - 1)) mark_ok_nxt = shift_word == cfg.begin_marker;
        if (cnt_r == CNT_W'(HDR_BYTES - 1))  total_nxt   = shift_word;
      end
      S_HDR_EVAL: begin
        priority if (hdr_bad_mark) begin
          sts_nxt = STS_MARKER;
        end else if (hdr_bad_len) begin
          sts_nxt = STS_BAD_LEN;
        end else if (hdr_small) begin
          sts_nxt  = STS_SMALL_BUF;
          mlen_nxt = LEN_W'(total_r - WORD_W'(FRAME_BYTES));
        end else begin
          rcur_nxt    = head_r + ADDR_W'(HDR_BYTES);
          rrem_nxt    = LEN_W'(total_r - WORD_W'(FRAME_BYTES));
          msg_len_nxt = LEN_W'(total_r - WORD_W'(FRAME_BYTES));
          ropen_nxt   = 1'b1;
        end
      end
      S_POP_BODY: begin
        mlen_nxt = msg_len_r;
        cnt_nxt  = '0;
      end
      S_POP_CAP: begin
        dout_nxt = mem_rdata;
        rcur_nxt = rcur_r + ADDR_W'(1);
        rrem_nxt = rrem_r - LEN_W'(1);
      end
      S_END_CAP: begin
        word_nxt = shift_word;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MARK_BYTES - 1)) begin
          ropen_nxt = 1'b0;
          if (shift_word != cfg.end_marker) begin
            sts_nxt  = STS_MARKER;
            dout_nxt = '0;
          end else begin
            head_nxt = rcur_r + ADDR_W'(MARK_BYTES);
            last_nxt = 1'b1;
          end
        end
      end
      S_HDR_RD, S_END_RD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // ring port and result outputs
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = head_r;
    mem_req.wdata = '0;
    unique case (state_r)
      S_RSV_HDR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = tail_r + ADDR_W'(cnt_r);
        mem_req.wdata = cnt_r[2] ? word_byte(WORD_W'(plen_r) + WORD_W'(FRAME_BYTES),
                                             cnt_r[1:0])
                                 : word_byte(cfg.begin_marker, cnt_r[1:0]);
      end
      S_PUSH: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = wcur_r;
        mem_req.wdata = byte_r;
      end
      S_END_WR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = wcur_r + ADDR_W'(cnt_r);
        mem_req.wdata = word_byte(cfg.end_marker, cnt_r[1:0]);
      end
      S_HDR_RD:   mem_req.addr = head_r + ADDR_W'(cnt_r);
      S_POP_BODY: mem_req.addr = rcur_r;
      S_END_RD:   mem_req.addr = rcur_r + ADDR_W'(cnt_r);
      default: begin
      end
    endcase
    busy       = state_r != S_IDLE;
    res_valid  = state_r == S_DONE;
    res_status = sts_r;
    res_data   = dout_r;
    res_last   = last_r;
    res_len    = mlen_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      wcur_r  <= '0;
      rcur_r  <= '0;
      wrem_r  <= '0;
      rrem_r  <= '0;
      wopen_r <= 1'b0;
      ropen_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      wcur_r  <= wcur_nxt;
      rcur_r  <= rcur_nxt;
      wrem_r  <= wrem_nxt;
      rrem_r  <= rrem_nxt;
      wopen_r <= wopen_nxt;
      ropen_r <= ropen_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    msg_len_r <= msg_len_nxt;
    word_r    <= word_nxt;
    total_r   <= total_nxt;
    mark_ok_r <= mark_ok_nxt;
    byte_r    <= byte_nxt;
    plen_r    <= plen_nxt;
    blim_r    <= blim_nxt;
    sts_r     <= sts_nxt;
    dout_r    <= dout_nxt;
    last_r    <= last_nxt;
    mlen_r    <= mlen_nxt;
  end

endmodule

// File: design/framed_byte_ring_queue.sv
// framed_byte_ring_queue: top level with register port, sequencer and ring memory
// depends on fbrq_pkg, fbrq_ctrl, fbrq_ram
// Steps: a push writes its byte, and the end marker when it closes the message;
//   a reserve writes the header, and the end marker too for an empty payload;
//   a pop reads the header first on the first pop of a message, then at most one
//   payload byte, then the end marker on the last pop. All use the single ring port,
//   so a new command is taken only after the last result; busy stays high throughout.
// Reset: synchronous, active low; clears pointers and open flags, not the ring.
module framed_byte_ring_queue (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fbrq_pkg::CMD_W-1:0]           in_command,
  input  logic [fbrq_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic [fbrq_pkg::LEN_W-1:0]           in_payload_length,
  input  logic [fbrq_pkg::LEN_W-1:0]           in_buffer_limit,
  output logic                                 out_valid,
  output logic [fbrq_pkg::STAT_W-1:0]          out_status,
  output logic [fbrq_pkg::BYTE_W-1:0]          out_data_out,
  output logic                                 out_last_byte,
  output logic [fbrq_pkg::LEN_W-1:0]           out_message_length,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fbrq_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [fbrq_pkg::WORD_W-1:0]          pwdata,
  output logic [fbrq_pkg::WORD_W-1:0]          prdata,
  output logic                                 pready
);
  import fbrq_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  mem_req_t          mem_req;
  logic [BYTE_W-1:0] mem_rdata;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_BEGIN: cfg_nxt.begin_marker = pwdata;
        REG_END:   cfg_nxt.end_marker   = pwdata;
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.begin_marker <= '0;
      cfg_r.end_marker   <= END_MARKER_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register reads
  assign prdata = (paddr[2] == REG_END) ? cfg_r.end_marker : cfg_r.begin_marker;

  fbrq_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .command        (in_command),
    .data_byte      (in_data_byte),
    .payload_length (in_payload_length),
    .buffer_limit   (in_buffer_limit),
    .cfg            (cfg_r),
    .busy           (busy),
    .res_valid      (out_valid),
    .res_status     (out_status),
    .res_data       (out_data_out),
    .res_last       (out_last_byte),
    .res_len        (out_message_length),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  fbrq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

endmodule

// File: design/fbrq_chk.sv
// fbrq_chk: port-level checks of the framed byte ring queue, bound to the top
// depends on fbrq_pkg and framed_byte_ring_queue
module fbrq_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic [fbrq_pkg::STAT_W-1:0]          out_status,
  input logic [fbrq_pkg::BYTE_W-1:0]          out_data_out,
  input logic                                 out_last_byte
);
  import fbrq_pkg::*;

  // an accepted command holds the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transfer did not raise busy");

  // a result only appears while a command is in flight, then the block frees up
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 !busy) else $error("result outside a busy window");

  // the message end strobe only comes with a good status
  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_status == STS_OK)
    else $error("last byte with error status");

  // failed commands return no data
  a_err_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STS_OK) |-> out_data_out == '0)
    else $error("data on failed transfer");

endmodule

bind framed_byte_ring_queue fbrq_chk u_fbrq_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_data_out  (out_data_out),
  .out_last_byte (out_last_byte)
);

// File: tb/testbench.sv
// testbench: self-checking bench for framed_byte_ring_queue
// holds a queue-occupancy predictor in a small scoreboard class; drives commands and apb writes
// depends on fbrq_pkg and the framed_byte_ring_queue rtl
module testbench;
  import fbrq_pkg::*;

  localparam logic [CMD_W-1:0]      CMD_UNUSED   = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_BEGIN_M = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_END_M   = 3'd4;
  localparam int CYCLE_LIMIT  = 900000;
  localparam int PHASE_ITEMS  = 280;
  localparam logic [LEN_W-1:0] WIDE_LIMIT = 13'h1FFF;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  mlen;
  } result_t;

  // ring occupancy predictor and store of expected results
  class ring_scoreboard;
    logic [BYTE_W-1:0] ring [RING_BYTES];
    logic [ADDR_W-1:0] head, tail, wr_cur, rd_cur;
    int unsigned       wr_rem, rd_rem;
    bit                wr_open, rd_open;
    logic [WORD_W-1:0] begin_m, end_m;
    result_t           pending_q[$];
    int                fails;

    function new();
      head = '0; tail = '0; wr_cur = '0; rd_cur = '0;
      wr_rem = 0; rd_rem = 0; wr_open = 0; rd_open = 0;
      begin_m = '0; end_m = END_MARKER_RESET; fails = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] a, logic [WORD_W-1:0] v);
      if (a[2] == REG_END) end_m = v;
      else begin_m = v;
    endfunction

    function logic [WORD_W-1:0] rd32(logic [ADDR_W-1:0] p);
      logic [WORD_W-1:0] v;
      logic [ADDR_W-1:0] a;
      v = '0;
      for (int k = 0; k < 4; k++) begin
        a = p + ADDR_W'(k);
        v[8*k +: 8] = ring[a];
      end
      return v;
    endfunction

    function void wr32(logic [ADDR_W-1:0] p, logic [WORD_W-1:0] v);
      logic [ADDR_W-1:0] a;
      for (int k = 0; k < 4; k++) begin
        a = p + ADDR_W'(k);
        ring[a] = v[8*k +: 8];
      end
    endfunction

    function void close_write();
      wr32(wr_cur, end_m);
      tail = wr_cur + ADDR_W'(4);
      wr_open = 0;
      wr_rem = 0;
    endfunction

    function bit drained();
      return head == tail && !rd_open;
    endfunction

    // note an accepted command transfer and predict its result
    function void note_input(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] db,
                             logic [LEN_W-1:0] plen, logic [LEN_W-1:0] blim);
      result_t r;
      int freeb, used;
      logic [WORD_W-1:0] total;
      bit go;
      r.status = STS_OK; r.data = '0; r.last = 0; r.mlen = '0;
      case (cmd)
        CMD_RESERVE: begin
          freeb = head <= tail ? RING_BYTES - int'(tail) + int'(head)
                               : int'(head) - int'(tail);
          wr_open = 0;
          wr_rem = 0;
          if (int'(plen) + FRAME_BYTES >= freeb) begin
            r.status = STS_FULL;
          end else begin
            wr32(tail, begin_m);
            wr32(tail + ADDR_W'(4), WORD_W'(plen) + WORD_W'(FRAME_BYTES));
            wr_cur = tail + ADDR_W'(HDR_BYTES);
            wr_rem = plen;
            wr_open = 1;
            if (plen == 0) close_write();
          end
        end
        CMD_PUSH: begin
          if (!wr_open) begin
            r.status = STS_SEQUENCE;
          end else begin
            ring[wr_cur] = db;
            wr_cur = wr_cur + ADDR_W'(1);
            wr_rem--;
            if (wr_rem == 0) close_write();
          end
        end
        CMD_POP: begin
          go = 1;
          // header checks at the start of a message
          if (!rd_open) begin
            if (head == tail) begin
              r.status = STS_EMPTY;
              go = 0;
            end else begin
              used = head < tail ? int'(tail) - int'(head)
                                 : RING_BYTES + int'(tail) - int'(head);
              total = rd32(head + ADDR_W'(4));
              if (rd32(head) != begin_m) begin
                r.status = STS_MARKER;
                go = 0;
              end else if (total > WORD_W'(used) || total < WORD_W'(FRAME_BYTES)) begin
                r.status = STS_BAD_LEN;
                go = 0;
              end else if (total - WORD_W'(HDR_BYTES) > WORD_W'(blim)) begin
                r.status = STS_SMALL_BUF;
                r.mlen = LEN_W'(total - WORD_W'(FRAME_BYTES));
                go = 0;
              end else begin
                rd_cur = head + ADDR_W'(HDR_BYTES);
                rd_rem = total - WORD_W'(FRAME_BYTES);
                rd_open = 1;
              end
            end
          end
          if (go) begin
            r.mlen = LEN_W'(rd32(head + ADDR_W'(4)) - WORD_W'(FRAME_BYTES));
            if (rd_rem != 0) begin
              r.data = ring[rd_cur];
              rd_cur = rd_cur + ADDR_W'(1);
              rd_rem--;
            end
            // end marker check closes the message
            if (rd_rem == 0) begin
              rd_open = 0;
              if (rd32(rd_cur) != end_m) begin
                r.status = STS_MARKER;
                r.data = '0;
              end else begin
                head = rd_cur + ADDR_W'(MARK_BYTES);
                r.last = 1;
              end
            end
          end
        end
        default: r.status = STS_SEQUENCE;
      endcase
      pending_q.push_back(r);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(result_t got);
      result_t e;
      if (pending_q.size() == 0) begin
        $error("result with no expectation: status %0d", got.status);
        fails++;
        return;
      end
      e = pending_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, got.status);
        fails++;
      end
      if (got.data !== e.data) begin
        $error("data_out: expected %0h actual %0h", e.data, got.data);
        fails++;
      end
      if (got.last !== e.last) begin
        $error("last_byte: expected %0b actual %0b", e.last, got.last);
        fails++;
      end
      if (got.mlen !== e.mlen) begin
        $error("message_length: expected %0d actual %0d", e.mlen, got.mlen);
        fails++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic [CMD_W-1:0]      in_command;
  logic [BYTE_W-1:0]     in_data_byte;
  logic [LEN_W-1:0]      in_payload_length, in_buffer_limit;
  logic                  out_valid, out_last_byte;
  logic [STAT_W-1:0]     out_status;
  logic [BYTE_W-1:0]     out_data_out;
  logic [LEN_W-1:0]      out_message_length;
  logic                  psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [WORD_W-1:0]     pwdata, prdata;

  ring_scoreboard sb;
  int cycles = 0;
  int items_sent = 0;
  int quiet_left = 0;

  framed_byte_ring_queue dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_data_byte(in_data_byte),
    .in_payload_length(in_payload_length), .in_buffer_limit(in_buffer_limit),
    .out_valid(out_valid), .out_status(out_status), .out_data_out(out_data_out),
    .out_last_byte(out_last_byte), .out_message_length(out_message_length),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid)
      sb.check_result('{out_status, out_data_out, out_last_byte, out_message_length});
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // idle length before a transfer: mostly short, a few long, some quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) quiet_left = $urandom_range(10, 40);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one command transfer; start stays high when the next follows at once
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] db,
                           logic [LEN_W-1:0] plen, logic [LEN_W-1:0] blim);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_data_byte <= db;
    in_payload_length <= plen;
    in_buffer_limit <= blim;
    do @(posedge clk); while (busy);
    sb.note_input(cmd, db, plen, blim);
    items_sent++;
  endtask

  task automatic pop_item(logic [LEN_W-1:0] blim);
    send_item(CMD_POP, BYTE_W'($urandom), LEN_W'($urandom), blim);
  endtask

  // a reserve and its payload; a short count leaves the message open
  task automatic write_message(logic [LEN_W-1:0] plen, int pushes);
    send_item(CMD_RESERVE, BYTE_W'($urandom), plen, LEN_W'($urandom));
    for (int i = 0; i < pushes; i++)
      send_item(CMD_PUSH, BYTE_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
  endtask

  // wait for outstanding results, then the block is idle
  task automatic settle();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // apb write: setup then access cycle
  task automatic reg_write(logic [CFG_ADDR_W-1:0] a, logic [WORD_W-1:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(a, v);
    @(posedge clk);
  endtask

  task automatic drain();
    while (!sb.drained()) pop_item(WIDE_LIMIT);
  endtask

  task automatic random_phase(int target);
    int r, plen, pushes;
    logic [LEN_W-1:0] blim;
    target += items_sent;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 39) == 0) plen = $urandom_range(0, 8179);
        else if ($urandom_range(0, 9) == 0) plen = $urandom_range(0, 300);
        else plen = $urandom_range(0, 24);
        pushes = plen;
        if ($urandom_range(0, 9) == 0 || plen > 300)
          pushes = $urandom_range(0, plen < 6 ? plen : 6);
        write_message(LEN_W'(plen), pushes);
      end else if (r < 85) begin
        for (int k = $urandom_range(1, 30); k > 0; k--) begin
          blim = $urandom_range(0, 7) == 0 ? LEN_W'($urandom) : WIDE_LIMIT;
          pop_item(blim);
        end
      end else begin
        send_item(CMD_W'($urandom), BYTE_W'($urandom),
                  LEN_W'($urandom_range(0, 8179)), LEN_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [WORD_W-1:0] bm, em;
    sb = new();
    rst_n = 1'b0; start = 1'b0;
    in_command = CMD_RESERVE; in_data_byte = '0;
    in_payload_length = '0; in_buffer_limit = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_write(ADDR_BEGIN_M, 32'hA5C3_0F96);
    reg_write(ADDR_END_M, END_MARKER_RESET);

    // directed: empty, sequence errors, full, abandon, zero payload, small buffer
    pop_item(WIDE_LIMIT);
    send_item(CMD_PUSH, 8'hFF, '0, '0);
    send_item(CMD_UNUSED, 8'h00, 13'h1FFF, 13'h1FFF);
    send_item(CMD_RESERVE, 8'h00, 13'd8180, '0);
    write_message(13'd8179, 2);
    write_message(13'd0, 0);
    pop_item(13'd0);
    pop_item(13'd4);
    send_item(CMD_RESERVE, 8'h00, 13'd3, '0);
    send_item(CMD_PUSH, 8'h00, '0, '0);
    send_item(CMD_PUSH, 8'hFF, '0, '0);
    send_item(CMD_PUSH, 8'h5A, '0, '0);
    pop_item(13'd6);
    pop_item(WIDE_LIMIT);
    pop_item(WIDE_LIMIT);
    pop_item(WIDE_LIMIT);
    write_message(13'd2, 2);
    settle();
    // end marker changed under a stored message, then restored
    reg_write(ADDR_END_M, 32'h0000_0000);
    pop_item(WIDE_LIMIT);
    pop_item(WIDE_LIMIT);
    pop_item(WIDE_LIMIT);
    settle();
    reg_write(ADDR_END_M, END_MARKER_RESET);
    drain();

    // random phases over several marker settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin bm = 32'h0; em = END_MARKER_RESET; end
        1: begin bm = 32'hFFFF_FFFF; em = 32'hFFFF_FFFF; end
        2: begin bm = 32'h0; em = 32'h0; end
        default: begin bm = $urandom; em = $urandom; end
      endcase
      settle();
      reg_write(ADDR_BEGIN_M, bm);
      reg_write(ADDR_END_M, em);
      random_phase(PHASE_ITEMS);
      drain();
    end

    settle();
    repeat (60) @(posedge clk);
    if (sb.fails == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
